>>> hw/rtl/hysteresis_thermostat_controller_macros.svh
// Assertion helpers for the top-level RTL.
`ifndef HYSTERESIS_THERMOSTAT_CONTROLLER_MACROS_SVH
`define HYSTERESIS_THERMOSTAT_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define HTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htc assertion failed");

// Next-cycle implication, disabled in reset.
`define HTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htc assertion failed");

`endif

>>> hw/rtl/htc_pkg.sv
`default_nettype none
package htc_pkg;

  localparam int unsigned TempW = 16;
  localparam int unsigned ThW   = 14;
  localparam int unsigned ActW  = 3;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned CmpW  = TempW + 2;

  localparam int unsigned ActHeat = 0;
  localparam int unsigned ActCool = 1;
  localparam int unsigned ActCirc = 2;

  typedef enum logic [IdxW-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_SP_HEAT   = 3'd1,
    REG_SP_COOL   = 3'd2,
    REG_EDGE_A    = 3'd3,
    REG_EDGE_B    = 3'd4,
    REG_ALLOWED   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        [ThW-1:0]   threshold;
    logic signed [TempW-1:0] sp_heat;
    logic signed [TempW-1:0] sp_cool;
    logic signed [TempW-1:0] edge_a;
    logic signed [TempW-1:0] edge_b;
    logic        [ActW-1:0]  allowed;
  } cfg_t;

  typedef struct packed {
    logic [ActW-1:0] actions;
    logic            conflict;
  } decision_t;

endpackage
`default_nettype wire

>>> hw/rtl/htc_cfg_regs.sv
`default_nettype none
module htc_cfg_regs
  import htc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [IdxW-1:0]  wr_index,
  input  wire logic [TempW-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= ThW'(50);
      cfg_r.sp_heat   <= TempW'(2000);
      cfg_r.sp_cool   <= TempW'(2600);
      cfg_r.edge_a    <= TempW'(1500);
      cfg_r.edge_b    <= TempW'(3000);
      cfg_r.allowed   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_THRESHOLD: cfg_r.threshold <= wr_data[ThW-1:0];
        REG_SP_HEAT:   cfg_r.sp_heat   <= $signed(wr_data);
        REG_SP_COOL:   cfg_r.sp_cool   <= $signed(wr_data);
        REG_EDGE_A:    cfg_r.edge_a    <= $signed(wr_data);
        REG_EDGE_B:    cfg_r.edge_b    <= $signed(wr_data);
        REG_ALLOWED:   cfg_r.allowed   <= wr_data[ActW-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> hw/rtl/htc_decide.sv
`default_nettype none
module htc_decide
  import htc_pkg::*;
(
  input  wire logic signed [TempW-1:0] temp,
  input  wire logic        [ActW-1:0]  cur,
  input  wire cfg_t                    cfg,
  output decision_t                    dec
);

  logic signed [CmpW-1:0] t, th, sh, sc, lo, hi;
  logic [ActW-1:0] prop, masked;

  always_comb begin
    t  = CmpW'(temp);
    th = $signed({{(CmpW-ThW){1'b0}}, cfg.threshold});
    sh = CmpW'(cfg.sp_heat);
    sc = CmpW'(cfg.sp_cool);
    if (cfg.edge_a > cfg.edge_b) begin
      hi = CmpW'(cfg.edge_a);
      lo = CmpW'(cfg.edge_b);
    end else begin
      hi = CmpW'(cfg.edge_b);
      lo = CmpW'(cfg.edge_a);
    end

    prop = cur;

    if (cur[ActHeat]) begin
      if (t > sh + th) prop[ActHeat] = 1'b0;
    end else if (t < sh - th) begin
      prop[ActHeat] = 1'b1;
    end

    if (cur[ActCool]) begin
      if (t < sc - th) prop[ActCool] = 1'b0;
    end else if (t > sc + th) begin
      prop[ActCool] = 1'b1;
    end

    if (cur[ActCirc]) begin
      if ((t > lo + th) && (t < hi - th)) prop[ActCirc] = 1'b0;
    end else if ((t < lo - th) || (t > hi + th)) begin
      prop[ActCirc] = 1'b1;
    end

    masked = prop & cfg.allowed;

    dec.conflict = masked[ActHeat] & masked[ActCool];
    dec.actions  = masked;
    if (dec.conflict) begin
      dec.actions[ActHeat] = 1'b0;
      dec.actions[ActCool] = 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/hysteresis_thermostat_controller.sv
`default_nettype none
// Channel   Dir  Handshake              Payload
// in_       in   in_valid / in_stall    in_temperature (16 b signed)
// out_      out  out_valid / out_stall  out_actions, out_relay_*, out_conflict_dropped
// cfg_      in   cfg_valid / cfg_ready  cfg_index (3 b), cfg_wdata (16 b)
//
// One sample per cycle sustained while out_stall stays low; each input beat
// passes the input register, then decision logic into the result register.
// The action state feeds back within the decision stage, so back-to-back
// samples each see the previous sample's committed actions.
// Reset (rst_n low, synchronous) clears both pipeline valids, the action state
// and loads the register defaults.
// in_stall rises only when the input register is full and the result register
// is held by out_stall. cfg_ready is always high.
module hysteresis_thermostat_controller
  import htc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // sample channel
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [TempW-1:0] in_temperature,
  // result channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic             [ActW-1:0]  out_actions,
  output logic                         out_relay_call,
  output logic                         out_relay_switchover,
  output logic                         out_relay_fan,
  output logic                         out_conflict_dropped,
  // register writes
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic        [IdxW-1:0]  cfg_index,
  input  wire logic        [TempW-1:0] cfg_wdata
);

  cfg_t      cfg;
  decision_t dec;

  // input register stage
  logic                    s1_valid_r;
  logic signed [TempW-1:0] s1_temp_r;

  // result register stage
  logic                    out_valid_r;
  logic        [ActW-1:0]  out_actions_r;
  logic                    out_conflict_r;

  // committed action bits
  logic        [ActW-1:0]  cur_actions_r;

  logic out_free, s1_move, in_take;

  assign cfg_ready = 1'b1;

  htc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  htc_decide u_decide (
    .temp (s1_temp_r),
    .cur  (cur_actions_r),
    .cfg  (cfg),
    .dec  (dec)
  );

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_temp_r <= in_temperature;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      cur_actions_r <= '0;
    end else begin
      if (s1_move) begin
        out_valid_r   <= 1'b1;
        cur_actions_r <= dec.actions; // commit with the result beat
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_actions_r  <= dec.actions;
      out_conflict_r <= dec.conflict;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_actions          = out_actions_r;
  assign out_relay_call       = out_actions_r[ActHeat] | out_actions_r[ActCool];
  assign out_relay_switchover = out_actions_r[ActCool];
  assign out_relay_fan        = |out_actions_r;
  assign out_conflict_dropped = out_conflict_r;

`include "hysteresis_thermostat_controller_macros.svh"

  // the held result always mirrors the committed state
  `HTC_ASSERT_NOW(a_state_matches_out, clk, rst_n, out_valid_r, cur_actions_r == out_actions_r)
  // heat and cool never leave together
  `HTC_ASSERT_NOW(a_no_heat_cool, clk, rst_n, out_valid_r, !(out_actions_r[ActHeat] && out_actions_r[ActCool]))
  // back-pressure only with a sample waiting
  `HTC_ASSERT_NOW(a_stall_needs_s1, clk, rst_n, in_stall, s1_valid_r && out_valid_r)
  // a stalled result keeps the state frozen
  `HTC_ASSERT_NEXT(a_state_hold, clk, rst_n, out_valid_r && out_stall, $stable(cur_actions_r))

endmodule
`default_nettype wire

>>> tb/sv/hysteresis_thermostat_controller_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the hysteresis thermostat controller.
// Samples are fed from a backlog by a clocked driver; each accepted beat is run
// through a behavioural copy of the decision logic, and the monitor compares
// every result beat against the oldest outstanding decision.
module hysteresis_thermostat_controller_tb;
  import htc_pkg::*;

  // Indexes past the end of the register map: writes there must be ignored.
  localparam logic [IdxW-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [IdxW-1:0] REG_UNUSED_HI = 3'd7;

  localparam int TEMP_MIN     = -32768;
  localparam int TEMP_MAX     = 32767;
  localparam int QUIET_CYCLES = 8;    // two-stage pipe, plus margin
  localparam int STALL_LIMIT  = 500;  // cycles without any beat before giving up

  // One committed decision as it appears on the result channel.
  typedef struct packed {
    logic [ActW-1:0] actions;
    logic            call;
    logic            switchover;
    logic            fan;
    logic            conflict;
  } decision_word_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [TempW-1:0] in_temperature = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic        [ActW-1:0]  out_actions;
  logic                    out_relay_call;
  logic                    out_relay_switchover;
  logic                    out_relay_fan;
  logic                    out_conflict_dropped;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic        [IdxW-1:0]  cfg_index = '0;
  logic        [TempW-1:0] cfg_wdata = '0;

  // Shadow of the register file and of the action state, reset values loaded.
  cfg_t shadow_cfg = '{threshold: 14'd50, sp_heat: 16'sd2000, sp_cool: 16'sd2600,
                       edge_a: 16'sd1500, edge_b: 16'sd3000, allowed: 3'b000};
  logic [ActW-1:0] held_actions = '0;

  logic signed [TempW-1:0] sample_backlog[$];    // samples not yet offered
  decision_word_t          awaited_decisions[$]; // predicted, not yet seen

  int in_gap_pct      = 9;
  int out_stall_pct   = 9;
  int mismatch_count  = 0;
  int samples_taken   = 0;
  int settings_count  = 0;
  int heat_seen       = 0;
  int cool_seen       = 0;
  int circ_seen       = 0;
  int conflicts_seen  = 0;
  int quiet_run       = 0;

  hysteresis_thermostat_controller dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_temperature       (in_temperature),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_actions          (out_actions),
    .out_relay_call       (out_relay_call),
    .out_relay_switchover (out_relay_switchover),
    .out_relay_fan        (out_relay_fan),
    .out_conflict_dropped (out_conflict_dropped),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decision logic, worked in 32-bit ints so that setpoint +/- threshold can
  // run well past the 16-bit sample range without wrapping.
  // ---------------------------------------------------------------------------
  function automatic decision_word_t decide_actions(input logic signed [TempW-1:0] temp_s,
                                                    input logic [ActW-1:0] cur);
    int t, th, sh, sc, lo, hi;
    logic [ActW-1:0] p;
    decision_word_t d;
    t  = temp_s;
    th = shadow_cfg.threshold;
    sh = $signed(shadow_cfg.sp_heat);
    sc = $signed(shadow_cfg.sp_cool);
    lo = $signed(shadow_cfg.edge_a);
    hi = $signed(shadow_cfg.edge_b);
    if (lo > hi) {lo, hi} = {hi, lo};  // edges may come in either order
    p = cur;
    d = '0;

    // heat: on below sp - th, off above sp + th
    if (cur[ActHeat] && t > sh + th) p[ActHeat] = 1'b0;
    else if (!cur[ActHeat] && t < sh - th) p[ActHeat] = 1'b1;

    // cool: mirror image
    if (cur[ActCool] && t < sc - th) p[ActCool] = 1'b0;
    else if (!cur[ActCool] && t > sc + th) p[ActCool] = 1'b1;

    // circulate: on outside the widened band, off only strictly inside the
    // narrowed one; a band under 2*th wide never lets it go off
    if (cur[ActCirc]) begin
      if (t > lo + th && t < hi - th) p[ActCirc] = 1'b0;
    end else if (t < lo - th || t > hi + th) begin
      p[ActCirc] = 1'b1;
    end

    p &= shadow_cfg.allowed;

    // heat and cool together: drop both, circulation survives
    if (p[ActHeat] && p[ActCool]) begin
      p[ActHeat] = 1'b0;
      p[ActCool] = 1'b0;
      d.conflict = 1'b1;
    end

    d.actions    = p;
    d.call       = p[ActHeat] | p[ActCool];
    d.switchover = p[ActCool];
    d.fan        = |p;
    return d;
  endfunction

  function automatic logic signed [TempW-1:0] sat16(input int v);
    if (v > TEMP_MAX) v = TEMP_MAX;
    if (v < TEMP_MIN) v = TEMP_MIN;
    return v[TempW-1:0];
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Sample driver: offers the backlog, holds the payload while stalled, and
  // predicts the result of every beat the block takes.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_samples
    decision_word_t d;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        d = decide_actions(in_temperature, held_actions);
        held_actions = d.actions;
        awaited_decisions.push_back(d);
        samples_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= in_gap_pct) begin
          in_valid       <= 1'b1;
          in_temperature <= sample_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random back-pressure, field-by-field compare.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    decision_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_decisions.size() == 0) begin
          flag_mismatch("result beat with no sample outstanding", 8'h0, 8'h0);
        end else begin
          want = awaited_decisions.pop_front();
          if (out_actions !== want.actions)
            flag_mismatch("actions", out_actions, want.actions);
          if (out_relay_call !== want.call)
            flag_mismatch("relay_call", out_relay_call, want.call);
          if (out_relay_switchover !== want.switchover)
            flag_mismatch("relay_switchover", out_relay_switchover, want.switchover);
          if (out_relay_fan !== want.fan)
            flag_mismatch("relay_fan", out_relay_fan, want.fan);
          if (out_conflict_dropped !== want.conflict)
            flag_mismatch("conflict_dropped", out_conflict_dropped, want.conflict);
          heat_seen      += want.actions[ActHeat];
          cool_seen      += want.actions[ActCool];
          circ_seen      += want.actions[ActCirc];
          conflicts_seen += want.conflict;
        end
      end
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_run <= 0;
      else
        quiet_run <= quiet_run + 1;
      if (quiet_run >= STALL_LIMIT) begin
        $display("[%0t] no progress for %0d cycles, %0d results outstanding",
                 $realtime, STALL_LIMIT, awaited_decisions.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All run in the initial process, aligned to a rising edge.
  // ---------------------------------------------------------------------------

  // Leaves cfg_valid high; the caller lowers it after the last write of a burst
  // so that back-to-back writes never see a low and a high in the same step.
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [TempW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_THRESHOLD: shadow_cfg.threshold = data[ThW-1:0];
      REG_SP_HEAT:   shadow_cfg.sp_heat   = data;
      REG_SP_COOL:   shadow_cfg.sp_cool   = data;
      REG_EDGE_A:    shadow_cfg.edge_a    = data;
      REG_EDGE_B:    shadow_cfg.edge_b    = data;
      REG_ALLOWED:   shadow_cfg.allowed   = data[ActW-1:0];
      default: ;  // unmapped index, nothing changes
    endcase
  endtask

  // Wait until the block has drained: nothing left to offer, no beat in
  // flight, every predicted result received; then let the pipe settle and
  // look again, since a last sample may only just have been put out.
  task automatic wait_quiet();
    do begin
      while (sample_backlog.size() != 0 || in_valid || awaited_decisions.size() != 0)
        @(posedge clk);
      repeat (QUIET_CYCLES) @(posedge clk);
    end while (sample_backlog.size() != 0 || in_valid || awaited_decisions.size() != 0);
  endtask

  task automatic queue_points(input int pts[$]);
    foreach (pts[i]) sample_backlog.push_back(sat16(pts[i]));
  endtask

  // Either rail or a fully random 16-bit word.
  function automatic logic [TempW-1:0] pick_wide();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return TempW'($urandom());
    endcase
  endfunction

  function automatic logic [TempW-1:0] pick_room();
    return sat16(1000 + int'($urandom_range(2500)));
  endfunction

  task automatic configure_random(input bit wide);
    logic [TempW-1:0] w;
    case ($urandom_range(5))
      0: w = 16'h0000;
      1: w = 16'hffff;                  // 16383 once the top bits are masked
      2: w = 16'd10000;
      3, 4: w = TempW'($urandom_range(300));
      default: w = TempW'($urandom());  // junk above bit 13 too
    endcase
    write_reg(REG_THRESHOLD, w);
    write_reg(REG_SP_HEAT, wide ? pick_wide() : pick_room());
    write_reg(REG_SP_COOL, wide ? pick_wide() : pick_room());
    w = wide ? pick_wide() : pick_room();
    write_reg(REG_EDGE_A, w);
    // now and then a zero-width band
    write_reg(REG_EDGE_B, ($urandom_range(5) == 0) ? w : (wide ? pick_wide() : pick_room()));
    w = TempW'($urandom());
    if ($urandom_range(1)) w[ActW-1:0] = '1;  // everything allowed half the time
    write_reg(REG_ALLOWED, w);
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI, TempW'($urandom()));
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // Mostly slow sweeps across a switching point, so the hysteresis state gets
  // walked in and out; the rest is exact edges, rails and plain noise.
  task automatic queue_samples(input int count);
    int anchor, span, pos, stride, run, added, th;
    logic [TempW-1:0] raw;
    added = 0;
    th    = shadow_cfg.threshold;
    span  = th + 200;
    while (added < count) begin
      case ($urandom_range(3))
        0: anchor = $signed(shadow_cfg.sp_heat);
        1: anchor = $signed(shadow_cfg.sp_cool);
        2: anchor = $signed(shadow_cfg.edge_a);
        default: anchor = $signed(shadow_cfg.edge_b);
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          pos    = anchor + int'($urandom_range(2 * span)) - span;
          stride = int'($urandom_range(th / 4 + 20, 1));
          if ($urandom_range(1)) stride = -stride;
          run = $urandom_range(20, 8);
          repeat (run) begin
            sample_backlog.push_back(sat16(pos));
            pos += stride;
            if ($urandom_range(5) == 0) stride = -stride;
            added++;
          end
        end
        6, 7: begin
          raw = TempW'($urandom());
          sample_backlog.push_back(raw);
          added++;
        end
        8: begin
          // just on, or one either side of, a switching point
          pos = anchor + ($urandom_range(1) ? th : -th) + int'($urandom_range(2)) - 1;
          sample_backlog.push_back(sat16(pos));
          added++;
        end
        default: begin
          sample_backlog.push_back(sat16($urandom_range(1) ? TEMP_MAX : TEMP_MIN));
          added++;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: nothing is allowed, so every decision is all-off.
    queue_points('{1000, TEMP_MIN, TEMP_MAX});
    wait_quiet();

    // Defaults again but with everything allowed; edges written reversed,
    // junk in the unused bits of threshold and mask, unmapped indexes poked.
    write_reg(REG_THRESHOLD, 16'hc032);
    write_reg(REG_SP_HEAT, 16'sd2000);
    write_reg(REG_SP_COOL, 16'sd2600);
    write_reg(REG_EDGE_A, 16'sd3000);
    write_reg(REG_EDGE_B, 16'sd1500);
    write_reg(REG_ALLOWED, 16'hffff);
    write_reg(REG_UNUSED_LO, 16'h1234);
    write_reg(REG_UNUSED_HI, 16'hffff);
    cfg_valid <= 1'b0;
    settings_count++;
    // walk the switching points, on each one or one count beyond it
    queue_points('{TEMP_MIN, 2050, 2051, 1950, 1949, 2650, 2651, 2550, 2549,
                   1450, 1449, 1551, 3050, 3051, 2950, TEMP_MAX, 0});
    wait_quiet();

    // Heat setpoint above cool with zero hysteresis: mid-range samples ask
    // for both, which must be dropped. Circulation masked off.
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_SP_HEAT, 16'sd2600);
    write_reg(REG_SP_COOL, 16'sd2000);
    write_reg(REG_ALLOWED, 16'd3);
    cfg_valid <= 1'b0;
    settings_count++;
    queue_points('{2300, 2300, TEMP_MIN, TEMP_MAX});
    wait_quiet();

    // Every register on a rail: sums run far outside 16 bits.
    write_reg(REG_THRESHOLD, 16'hffff);
    write_reg(REG_SP_HEAT, 16'h7fff);
    write_reg(REG_SP_COOL, 16'h8000);
    write_reg(REG_EDGE_A, 16'h8000);
    write_reg(REG_EDGE_B, 16'h7fff);
    write_reg(REG_ALLOWED, 16'd7);
    cfg_valid <= 1'b0;
    settings_count++;
    queue_points('{TEMP_MAX, TEMP_MIN, 0});
    wait_quiet();

    // Random phases, a fresh register setting each time.
    for (int ph = 0; ph < 12; ph++) begin
      configure_random(ph % 3 == 1);
      // one phase runs flat out, with neither side pausing
      in_gap_pct    = (ph == 5) ? 0 : 9;
      out_stall_pct = (ph == 5) ? 0 : 9;
      if (ph == 8) begin
        // sender holds off mid-phase until every result is back
        queue_samples(25);
        wait_quiet();
        queue_samples(30);
      end else begin
        queue_samples(55);
      end
      wait_quiet();
    end

    $display("covered %0d samples under %0d register settings, rails and masks included",
             samples_taken, settings_count);
    $display("results: heat %0d, cool %0d, circulate %0d, conflicts dropped %0d",
             heat_seen, cool_seen, circ_seen, conflicts_seen);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
